// ----- rtl/core/pmr_pkg.sv -----
// shared types, constants and codes of the per-peer message resequencer
`timescale 1ns / 1ps

package pmr_pkg;

  // sizing (PEERS and WINDOW are powers of two)
  localparam int unsigned PEERS       = 64;
  localparam int unsigned WINDOW      = 16;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned PEER_AW = $clog2(PEERS);
  localparam int unsigned WIN_AW  = $clog2(WINDOW);
  localparam int unsigned HND_AW  = PEER_AW + WIN_AW;
  localparam int unsigned CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] HND_MASK = 16'((64'd1 << HANDLE_BITS) - 64'd1);

  // command codes
  typedef enum logic {
    CMD_RX = 1'b0,
    CMD_TX = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    STS_PASS        = 3'd0,
    STS_DELIVERED   = 3'd1,
    STS_HELD        = 3'd2,
    STS_DROPPED     = 3'd3,
    STS_NUMBERED    = 3'd4,
    STS_SEND_PLAIN  = 3'd5,
    STS_SEND_IGNORE = 3'd6
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EMIT
  } fsm_t;

  // one input item
  typedef struct packed {
    logic        cmd;
    logic [5:0]  peer;
    logic [31:0] seq_num;
    logic [15:0] msg_handle;
    logic        numbering_used;
    logic        is_local;
    logic        universe_class;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] handle;
    logic [5:0]  peer;
    logic [31:0] seq;
    logic        last;
  } res_t;

  // per-peer state row: counters plus hold window occupancy
  typedef struct packed {
    logic [31:0]       exp;
    logic [31:0]       nxt;
    logic [WINDOW-1:0] mask;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // access request to the peer state memory
  typedef struct packed {
    logic               re;
    logic [PEER_AW-1:0] raddr;
    logic               we;
    logic [PEER_AW-1:0] waddr;
    row_t               wdata;
  } row_req_t;

  // access request to the held handle memory
  typedef struct packed {
    logic                   re;
    logic [HND_AW-1:0]      raddr;
    logic                   we;
    logic [HND_AW-1:0]      waddr;
    logic [HANDLE_BITS-1:0] wdata;
  } hnd_req_t;

endpackage

// ----- rtl/core/pmr_in_if.sv -----
// input channel interface: valid/ready plus one message item
`timescale 1ns / 1ps

interface pmr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  peer;
  logic [31:0] seq_num;
  logic [15:0] msg_handle;
  logic        numbering_used;
  logic        is_local;
  logic        universe_class;

  modport source (
    output valid, cmd, peer, seq_num, msg_handle, numbering_used, is_local,
           universe_class,
    input  ready
  );

  modport sink (
    input  valid, cmd, peer, seq_num, msg_handle, numbering_used, is_local,
           universe_class,
    output ready
  );
endinterface

// ----- rtl/core/pmr_out_if.sv -----
// result channel interface: valid/ready plus one result item
`timescale 1ns / 1ps

interface pmr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_handle;
  logic [5:0]  out_peer;
  logic [31:0] out_seq;
  logic        last;

  modport source (
    output valid, status, out_handle, out_peer, out_seq, last,
    input  ready
  );

  modport sink (
    input  valid, status, out_handle, out_peer, out_seq, last,
    output ready
  );
endinterface

// ----- rtl/core/per_peer_message_resequencer.sv -----
// top level: peer state and held handle memories around the sequencer
//
//   channel   dir  handshake          contents
//   in_ch     in   valid/ready        cmd, peer, seq_num, msg_handle, flags
//   out_ch    out  valid/ready        status, out_handle, out_peer, out_seq, last
//
// an item is accepted with a row read, then looked up and its row written back;
// each in-order held message released after it adds one result, up to 16 results
// per item, paced by the single read port of the held handle memory.
// synchronous active-low reset clears the per-peer row valid bits, so every
// peer starts with zero counters and an empty window; no clearing pass.
// a stalled result holds the sequencer; no new item is taken until the last
// result of the current one is in the output register.
`timescale 1ns / 1ps

module per_peer_message_resequencer import pmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pmr_in_if.sink     in_ch,
  pmr_out_if.source  out_ch
);

  in_item_t               in_item;
  row_req_t               row_req;
  row_t                   row_raw;
  row_t                   row_rdata;
  hnd_req_t               hnd_req;
  logic [HANDLE_BITS-1:0] hnd_rdata;
  res_t                   out_res;
  logic [PEERS-1:0]       row_vld_r;
  logic [PEER_AW-1:0]     rd_slot_r;

  // pack the input transfer
  assign in_item = '{cmd: in_ch.cmd, peer: in_ch.peer, seq_num: in_ch.seq_num,
                     msg_handle: in_ch.msg_handle,
                     numbering_used: in_ch.numbering_used,
                     is_local: in_ch.is_local, universe_class: in_ch.universe_class};

  // row valid bits: a never-written row reads as reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (row_req.we) begin
      row_vld_r[row_req.waddr] <= 1'b1;
    end
  end

  // remember which row the pending read belongs to
  always_ff @(posedge clk) begin
    if (row_req.re) begin
      rd_slot_r <= row_req.raddr;
    end
  end

  assign row_rdata = row_vld_r[rd_slot_r] ? row_raw : '0;

  // peer state memory
  pmr_ram #(.WIDTH(ROW_W), .DEPTH(PEERS)) u_row_ram (
    .clk   (clk),
    .we    (row_req.we),
    .waddr (row_req.waddr),
    .wdata (row_req.wdata),
    .re    (row_req.re),
    .raddr (row_req.raddr),
    .rdata (row_raw)
  );

  // held handle memory, one entry per peer and window position
  pmr_ram #(.WIDTH(HANDLE_BITS), .DEPTH(PEERS * WINDOW)) u_hnd_ram (
    .clk   (clk),
    .we    (hnd_req.we),
    .waddr (hnd_req.waddr),
    .wdata (hnd_req.wdata),
    .re    (hnd_req.re),
    .raddr (hnd_req.raddr),
    .rdata (hnd_rdata)
  );

  // sequencer
  pmr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .row_req   (row_req),
    .row_rdata (row_rdata),
    .hnd_req   (hnd_req),
    .hnd_rdata (hnd_rdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // unpack the result transfer
  assign out_ch.status     = out_res.status;
  assign out_ch.out_handle = out_res.handle;
  assign out_ch.out_peer   = out_res.peer;
  assign out_ch.out_seq    = out_res.seq;
  assign out_ch.last       = out_res.last;

endmodule

// ----- rtl/core/pmr_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/pmr_seq.sv -----
// sequencer: per-item read-modify-write of the peer row and drain of held messages
`timescale 1ns / 1ps

module pmr_seq import pmr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output row_req_t               row_req,
  input  row_t                   row_rdata,
  output hnd_req_t               hnd_req,
  input  logic [HANDLE_BITS-1:0] hnd_rdata,
  output logic                   out_valid,
  input  logic                   out_ready,
  output res_t                   out_res
);

  fsm_t                state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [31:0]         exp_r, exp_nxt;
  logic [31:0]         nxt_r, nxt_nxt;
  logic [WINDOW-1:0]   mask_r, mask_nxt;
  logic [31:0]         dseq_r, dseq_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  res_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [PEER_AW-1:0]  slot;
  logic                out_free;
  logic                rx_num;
  logic [31:0]         seq_gap;
  logic [WIN_AW-1:0]   seq_idx;
  logic                hold;
  logic [31:0]         e_new;
  logic [31:0]         n_new;
  logic [WINDOW-1:0]   m_new;
  logic [WIN_AW-1:0]   e_idx;
  logic                drain_go;
  res_t                first_res;
  logic [WIN_AW-1:0]   x_idx;
  logic [CNT_W-1:0]    cnt_inc;
  logic                more;

  assign slot     = item_r.peer[PEER_AW-1:0];
  assign out_free = !out_valid_r || out_ready;

  // first result of an item, from the freshly read row
  always_comb begin
    rx_num    = (item_r.cmd == CMD_RX) && item_r.numbering_used && item_r.is_local;
    seq_gap   = item_r.seq_num - row_rdata.exp;
    seq_idx   = item_r.seq_num[WIN_AW-1:0];
    hold      = 1'b0;
    e_new     = row_rdata.exp;
    n_new     = row_rdata.nxt;
    m_new     = row_rdata.mask;
    first_res = '{status: STS_PASS, handle: item_r.msg_handle & HND_MASK,
                  peer: item_r.peer, seq: 32'd0, last: 1'b1};
    if (item_r.cmd == CMD_TX) begin
      if (!item_r.is_local) begin
        first_res.status = STS_SEND_IGNORE;
      end else if (item_r.universe_class) begin
        first_res.status = STS_SEND_PLAIN;
      end else begin
        first_res.status = STS_NUMBERED;
        first_res.seq    = row_rdata.nxt;
        n_new            = row_rdata.nxt + 32'd1;
      end
    end else if (rx_num) begin
      first_res.seq = item_r.seq_num;
      if (seq_gap == 32'd0) begin
        first_res.status = STS_DELIVERED;
        e_new            = row_rdata.exp + 32'd1;
      end else begin
        hold = (seq_gap < 32'(WINDOW)) && !row_rdata.mask[seq_idx];
        if (hold) begin
          first_res.status = STS_HELD;
          m_new[seq_idx]   = 1'b1;
        end else begin
          first_res.status = STS_DROPPED;
        end
      end
    end
    e_idx          = e_new[WIN_AW-1:0];
    drain_go       = rx_num && m_new[e_idx];
    first_res.last = !drain_go;
  end

  // drain step: is there one more in-order held message within the result budget
  always_comb begin
    x_idx   = exp_r[WIN_AW-1:0];
    cnt_inc = cnt_r + CNT_W'(1);
    more    = mask_r[x_idx] && (cnt_inc < CNT_W'(MAX_RESULTS));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          state_nxt = drain_go ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free && !more) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs, memory requests and datapath updates
  always_comb begin
    in_ready      = 1'b0;
    row_req       = '0;
    hnd_req       = '0;
    item_nxt      = item_r;
    exp_nxt       = exp_r;
    nxt_nxt       = nxt_r;
    mask_nxt      = mask_r;
    dseq_nxt      = dseq_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        item_nxt      = in_item;
        row_req.re    = in_valid;
        row_req.raddr = in_item.peer[PEER_AW-1:0];
      end
      S_LOOK: begin
        if (out_free) begin
          out_nxt       = first_res;
          out_valid_nxt = 1'b1;
          if (drain_go) begin
            hnd_req.re      = 1'b1;
            hnd_req.raddr   = {slot, e_idx};
            dseq_nxt        = e_new;
            exp_nxt         = e_new + 32'd1;
            nxt_nxt         = n_new;
            mask_nxt        = m_new;
            mask_nxt[e_idx] = 1'b0;
            cnt_nxt         = CNT_W'(1);
          end else begin
            row_req.we    = 1'b1;
            row_req.waddr = slot;
            row_req.wdata = '{exp: e_new, nxt: n_new, mask: m_new};
          end
          if (hold) begin
            hnd_req.we    = 1'b1;
            hnd_req.waddr = {slot, seq_idx};
            hnd_req.wdata = HANDLE_BITS'(item_r.msg_handle);
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_nxt       = '{status: STS_DELIVERED, handle: 16'(hnd_rdata) & HND_MASK,
                            peer: item_r.peer, seq: dseq_r, last: !more};
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_inc;
          if (more) begin
            hnd_req.re      = 1'b1;
            hnd_req.raddr   = {slot, x_idx};
            dseq_nxt        = exp_r;
            exp_nxt         = exp_r + 32'd1;
            mask_nxt[x_idx] = 1'b0;
          end else begin
            row_req.we    = 1'b1;
            row_req.waddr = slot;
            row_req.wdata = '{exp: exp_r, nxt: nxt_r, mask: mask_r};
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    exp_r  <= exp_nxt;
    nxt_r  <= nxt_nxt;
    mask_r <= mask_nxt;
    dseq_r <= dseq_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // row is written back exactly once per item, never from idle
  a_row_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    row_req.we |-> (state_r == S_LOOK || state_r == S_EMIT))
    else $error("row write back outside of an item");

  // a hold never lands on the entry being drained in the same cycle
  a_hnd_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (hnd_req.re && hnd_req.we) |-> (hnd_req.raddr != hnd_req.waddr))
    else $error("held handle read and write collide");

  // drain keeps within the result budget
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r != '0 && cnt_r < CNT_W'(MAX_RESULTS)))
    else $error("drain count out of range");

  // the item ends with a last result as the sequencer returns to idle
  a_last_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_nxt == S_IDLE) |=> (out_valid_r && out_r.last))
    else $error("item finished without a last result");

  // an accepted item is looked up in the next cycle
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOOK))
    else $error("accepted item not looked up");

endmodule

// ----- tb/tb_top.sv -----
// testbench top: random and directed check of the per-peer message resequencer
`timescale 1ns / 1ps

module tb_top;
  import pmr_pkg::*;

  localparam int HOLD_LEN   = 200;
  localparam int STALL_LIM  = 2000;
  localparam int SEQ_PEERS  = 8;

  logic clk;
  logic rst_n;

  pmr_in_if  in_ch ();
  pmr_out_if out_ch ();

  per_peer_message_resequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the block state
  logic [31:0] rx_expect [PEERS];
  logic [31:0] tx_next   [PEERS];
  bit          held_full [PEERS*WINDOW];
  logic [15:0] held_tag  [PEERS*WINDOW];

  // traffic bookkeeping
  in_item_t    pending_items [$];
  res_t        due_results   [$];
  in_item_t    drv_item;
  in_item_t    seen_item;
  logic [31:0] gen_next [SEQ_PEERS];
  bit          in_taken;
  int          n_pushed, n_in, n_out, n_fail;
  int          n_held, n_dropped, max_burst;
  int          snd_idle_pct, rcv_stall_pct;
  bit          hold_on;
  int          hold_cnt;
  int          quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expected results of one accepted item, appended in order
  task automatic reorder_predict(input in_item_t it);
    res_t        burst [$];
    res_t        r;
    int          slot;
    int          idx;
    logic [31:0] e;
    logic [31:0] gap;
    logic [15:0] tag;
    slot = int'(it.peer) % PEERS;
    tag  = it.msg_handle & HND_MASK;
    r.handle = tag;
    r.peer   = it.peer;
    r.seq    = '0;
    r.last   = 1'b0;
    if (it.cmd == CMD_TX) begin
      if (!it.is_local) begin
        r.status = STS_SEND_IGNORE;
      end else if (it.universe_class) begin
        r.status = STS_SEND_PLAIN;
      end else begin
        r.status = STS_NUMBERED;
        r.seq    = tx_next[slot];
        tx_next[slot] = tx_next[slot] + 1;
      end
      burst.push_back(r);
    end else if (!it.numbering_used || !it.is_local) begin
      r.status = STS_PASS;
      burst.push_back(r);
    end else begin
      e     = rx_expect[slot];
      r.seq = it.seq_num;
      if (it.seq_num == e) begin
        r.status = STS_DELIVERED;
        rx_expect[slot] = e + 1;
      end else begin
        gap = it.seq_num - e;
        idx = slot * WINDOW + int'(it.seq_num % WINDOW);
        if (gap >= 1 && gap < WINDOW && !held_full[idx]) begin
          held_full[idx] = 1'b1;
          held_tag[idx]  = tag;
          r.status = STS_HELD;
          n_held++;
        end else begin
          r.status = STS_DROPPED;
          n_dropped++;
        end
      end
      burst.push_back(r);
      // release held messages that are now in order
      while (burst.size() < MAX_RESULTS) begin
        e   = rx_expect[slot];
        idx = slot * WINDOW + int'(e % WINDOW);
        if (!held_full[idx]) break;
        held_full[idx] = 1'b0;
        r.status = STS_DELIVERED;
        r.handle = held_tag[idx];
        r.seq    = e;
        burst.push_back(r);
        rx_expect[slot] = e + 1;
      end
    end
    burst[burst.size()-1].last = 1'b1;
    if (burst.size() > max_burst) max_burst = burst.size();
    foreach (burst[i]) due_results.push_back(burst[i]);
  endtask

  task automatic queue_item(input logic c, input logic [5:0] p, input logic [31:0] s,
                            input logic [15:0] h, input logic nu, input logic lo,
                            input logic un);
    in_item_t it;
    it.cmd            = c;
    it.peer           = p;
    it.seq_num        = s;
    it.msg_handle     = h;
    it.numbering_used = nu;
    it.is_local       = lo;
    it.universe_class = un;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  // shuffled in-window runs per peer, with tx traffic and noise mixed in
  task automatic gen_random(input int n);
    logic [31:0] nums [$];
    logic [31:0] tmp;
    logic [5:0]  p;
    int          made;
    int          pick;
    int          k;
    int          j;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        p = 6'($urandom_range(0, SEQ_PEERS - 1));
        k = $urandom_range(1, WINDOW);
        nums.delete();
        for (int i = 0; i < k; i++) nums.push_back(gen_next[p] + i);
        gen_next[p] = gen_next[p] + k;
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = nums[i];
          nums[i] = nums[j];
          nums[j] = tmp;
        end
        // broken run: a duplicate or a number beyond the window
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1))
            nums.insert($urandom_range(0, k), nums[$urandom_range(0, k - 1)]);
          else
            nums.insert($urandom_range(0, k), gen_next[p] + WINDOW + $urandom_range(0, 40));
        end
        foreach (nums[i]) queue_item(CMD_RX, p, nums[i], 16'($urandom), 1'b1, 1'b1, 1'b0);
        made += nums.size();
      end else if (pick < 80) begin
        queue_item(CMD_TX, 6'($urandom), $urandom, 16'($urandom),
                   1'($urandom), ($urandom_range(0, 3) != 0), 1'($urandom));
        made++;
      end else begin
        queue_item(CMD_RX, 6'($urandom), $urandom, 16'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (n_in != n_pushed || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int snd, input int rcv, input int n);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    gen_random(n);
    wait_drained();
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        drv_item = pending_items.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= drv_item.cmd;
        in_ch.peer           <= drv_item.peer;
        in_ch.seq_num        <= drv_item.seq_num;
        in_ch.msg_handle     <= drv_item.msg_handle;
        in_ch.numbering_used <= drv_item.numbering_used;
        in_ch.is_local       <= drv_item.is_local;
        in_ch.universe_class <= drv_item.universe_class;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_on && hold_cnt < HOLD_LEN) begin
      out_ch.ready <= 1'b0;
      hold_cnt++;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_fail++;
    end
  endfunction

  // monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        seen_item.cmd            = in_ch.cmd;
        seen_item.peer           = in_ch.peer;
        seen_item.seq_num        = in_ch.seq_num;
        seen_item.msg_handle     = in_ch.msg_handle;
        seen_item.numbering_used = in_ch.numbering_used;
        seen_item.is_local       = in_ch.is_local;
        seen_item.universe_class = in_ch.universe_class;
        reorder_predict(seen_item);
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d seq %0h",
                   $time, out_ch.status, out_ch.out_seq);
          n_fail++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("out_handle", 32'(want.handle), 32'(out_ch.out_handle));
          check_field("out_peer", 32'(want.peer), 32'(out_ch.out_peer));
          check_field("out_seq", want.seq, out_ch.out_seq);
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIM) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.peer = '0;
    in_ch.seq_num = '0;
    in_ch.msg_handle = '0;
    in_ch.numbering_used = 1'b0;
    in_ch.is_local = 1'b0;
    in_ch.universe_class = 1'b0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    hold_on = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    foreach (rx_expect[i]) begin
      rx_expect[i] = '0;
      tx_next[i] = '0;
    end
    foreach (held_full[i]) held_full[i] = 1'b0;
    foreach (gen_next[i]) gen_next[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: each send kind, the pass-through cases
    queue_item(CMD_TX, 6'd5, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    queue_item(CMD_TX, 6'd5, 32'h0, 16'h0001, 1'b0, 1'b1, 1'b1);
    queue_item(CMD_TX, 6'd5, 32'h0, 16'h0002, 1'b0, 1'b0, 1'b1);
    queue_item(CMD_RX, 6'd0, 32'h0, 16'h0003, 1'b0, 1'b1, 1'b0);
    queue_item(CMD_RX, 6'd0, 32'h0, 16'h0004, 1'b1, 1'b0, 1'b0);
    // hold, filled slot, too far ahead, wrapped behind
    queue_item(CMD_RX, 6'd63, 32'd3, 16'h0000, 1'b1, 1'b1, 1'b0);
    queue_item(CMD_RX, 6'd63, 32'd3, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    queue_item(CMD_RX, 6'd63, 32'd16, 16'h1234, 1'b1, 1'b1, 1'b0);
    queue_item(CMD_RX, 6'd63, 32'hFFFF_FFFF, 16'h4321, 1'b1, 1'b1, 1'b0);
    // fill the whole window, then release it all with the in-order one
    for (int s = WINDOW - 1; s >= 1; s--)
      if (s != 3) queue_item(CMD_RX, 6'd63, 32'(s), 16'(16'hA000 + s), 1'b1, 1'b1, 1'b0);
    queue_item(CMD_RX, 6'd63, 32'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    // old number after the drain
    queue_item(CMD_RX, 6'd63, 32'd0, 16'h5555, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // random traffic under each handshake mix
    run_phase(0, 0, 36);
    run_phase(62, 0, 36);
    run_phase(0, 62, 36);
    run_phase(38, 38, 36);

    // receiver holds off while the sender keeps offering
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_on = 1'b1;
    gen_random(22);
    while (hold_cnt < HOLD_LEN) @(negedge clk);
    hold_on = 1'b0;
    wait_drained();

    repeat (30) @(posedge clk);
    $display("covered %0d input transfers and %0d results under five handshake mixes",
             n_in, n_out);
    $display("including a %0d-cycle result hold-off; held %0d, dropped %0d, longest burst %0d",
             HOLD_LEN, n_held, n_dropped, max_burst);
    if (n_fail == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pmr_pkg.sv
rtl/core/pmr_in_if.sv
rtl/core/pmr_out_if.sv
rtl/core/pmr_ram.sv
rtl/core/pmr_seq.sv
rtl/core/per_peer_message_resequencer.sv
tb/tb_top.sv
